/* rtl/jpqr_pkg.sv */
// Shared types and constants for the jog pendant quadrature reporter.
package jpqr_pkg;

  // Report kinds carried on the result channel
  typedef enum logic [1:0] {
    KIND_STOP  = 2'd0,
    KIND_READY = 2'd1,
    KIND_STEP  = 2'd2
  } jpqr_kind_t;

  // Pin history patterns, oldest pair in the high bits
  localparam logic [5:0] HIST_DOWN = 6'b10_11_01;
  localparam logic [5:0] HIST_UP   = 6'b01_11_10;

  // Magnification values
  localparam logic [6:0] MAG_NONE    = 7'd0;
  localparam logic [6:0] MAG_X1      = 7'd1;
  localparam logic [6:0] MAG_X10     = 7'd10;
  localparam logic [6:0] MAG_HUNDRED = 7'd100;

  // Reset value of the heartbeat limit
  localparam logic [7:0] IDLE_READY_RESET = 8'd10;

  // Input command codes
  localparam logic CMD_PIN  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // One input item
  typedef struct packed {
    logic       command;
    logic       pin_a;
    logic       pin_b;
    logic       estop_level;
    logic [2:0] mag_switch_n;
    logic [3:0] axis_switch_n;
  } jpqr_item_t;

  // Decoder state
  typedef struct packed {
    logic [5:0]        pin_history;
    logic signed [7:0] step_accumulator;
    logic              was_stopped;
    logic [7:0]        idle_tick_count;
  } jpqr_state_t;

  // One result item
  typedef struct packed {
    jpqr_kind_t        report_kind;
    logic [2:0]        axis_number;
    logic [6:0]        magnification;
    logic signed [7:0] step_count;
  } jpqr_result_t;

endpackage

/* rtl/jpqr_core.sv */
// Single-pass step logic: next state and optional report for one item.
module jpqr_core (
  input  jpqr_pkg::jpqr_item_t   item,
  input  jpqr_pkg::jpqr_state_t  state,
  input  logic [7:0]             idle_ready_ticks,
  output jpqr_pkg::jpqr_state_t  state_next,
  output logic                   res_valid,
  output jpqr_pkg::jpqr_result_t result
);

  logic [5:0] hist_shift;
  logic [2:0] mags;
  logic [3:0] axes;
  logic [6:0] mag_sel;
  logic [2:0] axis_sel;
  logic       reported;
  logic [7:0] count_inc;

  // Decode the switch banks, highest active wins
  always_comb begin
    mags = ~item.mag_switch_n;
    axes = ~item.axis_switch_n;
    if (mags[2]) begin
      mag_sel = jpqr_pkg::MAG_HUNDRED;
    end else if (mags[1]) begin
      mag_sel = jpqr_pkg::MAG_X10;
    end else if (mags[0]) begin
      mag_sel = jpqr_pkg::MAG_X1;
    end else begin
      mag_sel = jpqr_pkg::MAG_NONE;
    end
    if (axes[3]) begin
      axis_sel = 3'd4;
    end else if (axes[2]) begin
      axis_sel = 3'd3;
    end else if (axes[1]) begin
      axis_sel = 3'd2;
    end else if (axes[0]) begin
      axis_sel = 3'd1;
    end else begin
      axis_sel = 3'd0;
    end
  end

  assign hist_shift = {state.pin_history[3:0], item.pin_b, item.pin_a};

  // Work out the new state and the report
  always_comb begin
    state_next         = state;
    reported           = 1'b0;
    count_inc          = 8'd0;
    result.report_kind = jpqr_pkg::KIND_READY;
    result.axis_number = 3'd0;
    result.magnification = jpqr_pkg::MAG_NONE;
    result.step_count  = 8'sd0;
    res_valid          = 1'b0;

    if (item.command == jpqr_pkg::CMD_PIN) begin
      // Shift in the pin pair and count a full detent
      state_next.pin_history = hist_shift;
      if (hist_shift == jpqr_pkg::HIST_DOWN) begin
        state_next.step_accumulator = state.step_accumulator - 8'sd1;
      end else if (hist_shift == jpqr_pkg::HIST_UP) begin
        state_next.step_accumulator = state.step_accumulator + 8'sd1;
      end
    end else begin
      if (item.estop_level) begin
        state_next.was_stopped = 1'b1;
        result.report_kind     = jpqr_pkg::KIND_STOP;
        reported               = 1'b1;
      end else if (state.was_stopped) begin
        state_next.was_stopped      = 1'b0;
        state_next.step_accumulator = 8'sd0;
        result.report_kind          = jpqr_pkg::KIND_READY;
        reported                    = 1'b1;
      end else begin
        state_next.step_accumulator = 8'sd0;
        if ((state.step_accumulator != 8'sd0) && (mag_sel != jpqr_pkg::MAG_NONE) &&
            (axis_sel != 3'd0)) begin
          result.report_kind   = jpqr_pkg::KIND_STEP;
          result.axis_number   = axis_sel;
          result.magnification = mag_sel;
          result.step_count    = state.step_accumulator;
          reported             = 1'b1;
        end
      end

      // Advance the heartbeat count, fire READY on a silent tick at the limit
      count_inc = (reported ? 8'd0 : state.idle_tick_count) + 8'd1;
      if (count_inc == idle_ready_ticks) begin
        state_next.idle_tick_count = 8'd0;
        if (!reported) begin
          result.report_kind = jpqr_pkg::KIND_READY;
          reported           = 1'b1;
        end
      end else begin
        state_next.idle_tick_count = count_inc;
      end
      res_valid = reported;
    end
  end

endmodule

/* rtl/jog_pendant_quadrature_reporter.sv */
// Top level of the jog pendant quadrature reporter: registers and handshakes.
//
//  channel   direction  handshake             payload
//  s_axis    in         s_tvalid / s_tready   s_tuser command, s_tdata pins and switches
//  m_axis    out        m_tvalid / m_tready   m_tuser report_kind, m_tdata axis, mag, steps
//  cfg       in         cfg_wr_en             cfg_wr_data idle_ready_ticks
//
// One item per cycle while m_tready does not stall: an item is held in the input
// register, and the step logic then updates the state and loads the result register.
// rst is synchronous; it clears the valid flags and the state but for
// was_stopped, which it sets, and sets the heartbeat limit to 10. A stall on
// m_tready holds the result register and, through the input register, s_tready.
module jog_pendant_quadrature_reporter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] pin_a, [1] pin_b, [2] estop_level,
                                 // [5:3] mag_switch_n, [9:6] axis_switch_n, rest zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] axis_number, [9:3] magnification,
                                 // [17:10] step_count, rest zero
  output logic [1:0]  m_tuser,   // [1:0] report_kind
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic                   item_valid;
  jpqr_pkg::jpqr_item_t   item;
  jpqr_pkg::jpqr_state_t  state;
  jpqr_pkg::jpqr_state_t  state_next;
  logic [7:0]             idle_ready_ticks;
  logic                   res_valid;
  jpqr_pkg::jpqr_result_t result;
  jpqr_pkg::jpqr_result_t out_result;
  logic                   out_valid;
  logic                   advance;

  assign advance  = item_valid && (!out_valid || m_tready);
  assign s_tready = !item_valid || advance;

  // Hold the heartbeat limit
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ready_ticks <= jpqr_pkg::IDLE_READY_RESET;
    end else if (cfg_wr_en) begin
      idle_ready_ticks <= cfg_wr_data;
    end
  end

  // Capture an input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command       <= s_tuser;
      item.pin_a         <= s_tdata[0];
      item.pin_b         <= s_tdata[1];
      item.estop_level   <= s_tdata[2];
      item.mag_switch_n  <= s_tdata[5:3];
      item.axis_switch_n <= s_tdata[9:6];
    end
  end

  jpqr_core u_core (
    .item             (item),
    .state            (state),
    .idle_ready_ticks (idle_ready_ticks),
    .state_next       (state_next),
    .res_valid        (res_valid),
    .result           (result)
  );

  // Advance the decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pin_history      <= 6'd0;
      state.step_accumulator <= 8'sd0;
      state.was_stopped      <= 1'b1;
      state.idle_tick_count  <= 8'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.report_kind;
  assign m_tdata  = {6'd0, out_result.step_count, out_result.magnification,
                     out_result.axis_number};

`ifndef SYNTHESIS
  // Only STEP reports carry axis, magnification and steps
  a_quiet_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != jpqr_pkg::KIND_STEP)) |-> (m_tdata == 24'd0))
    else $error("non-STEP report with nonzero payload");

  // A STEP report always names an axis, a magnification and nonzero steps
  a_step_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == jpqr_pkg::KIND_STEP)) |->
    ((m_tdata[2:0] != 3'd0) && (m_tdata[9:3] != 7'd0) && (m_tdata[17:10] != 8'd0)))
    else $error("STEP report with empty field");

  // A pin change leaves the result register untouched
  a_pin_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && (item.command == jpqr_pkg::CMD_PIN)) |=>
    ($stable(m_tdata) && $stable(m_tuser)))
    else $error("pin change altered the result register");

  // An emergency stop tick arms the was-stopped flag
  a_estop_arms: assert property (@(posedge clk) disable iff (rst)
    (advance && (item.command == jpqr_pkg::CMD_TICK) && item.estop_level) |=>
    state.was_stopped)
    else $error("estop tick did not arm the was-stopped flag");
`endif

endmodule

/* tb/sv/tb_jog_pendant_quadrature_reporter.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the jog pendant quadrature reporter.
module tb_jog_pendant_quadrature_reporter;

  // Predicts the pendant reports and checks them in order of arrival
  class jog_report_scoreboard;
    jpqr_pkg::jpqr_result_t report_q[$];
    logic [7:0]        heartbeat_limit;
    logic [5:0]        pin_hist;
    logic signed [7:0] detents;
    bit                stop_latched;
    logic [7:0]        silent_ticks;
    int                errors;
    int                items_seen;
    int                kind_seen[3];

    function void restart();
      heartbeat_limit = jpqr_pkg::IDLE_READY_RESET;
      pin_hist        = '0;
      detents         = '0;
      stop_latched    = 1'b1;
      silent_ticks    = '0;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // Advance the model state by one accepted transaction
    function void note_input(jpqr_pkg::jpqr_item_t it);
      jpqr_pkg::jpqr_result_t rep;
      bit                gave;
      logic [2:0]        mags;
      logic [3:0]        axes;
      logic signed [7:0] taken;
      rep  = '0;
      gave = 1'b0;
      items_seen++;
      if (it.command == jpqr_pkg::CMD_PIN) begin
        pin_hist = {pin_hist[3:0], it.pin_b, it.pin_a};
        if (pin_hist == jpqr_pkg::HIST_DOWN) detents = detents - 8'sd1;
        else if (pin_hist == jpqr_pkg::HIST_UP) detents = detents + 8'sd1;
        return;
      end
      if (it.estop_level) begin
        stop_latched    = 1'b1;
        rep.report_kind = jpqr_pkg::KIND_STOP;
        gave            = 1'b1;
      end else if (stop_latched) begin
        stop_latched    = 1'b0;
        detents         = '0;
        rep.report_kind = jpqr_pkg::KIND_READY;
        gave            = 1'b1;
      end else begin
        taken   = detents;
        detents = '0;
        mags    = ~it.mag_switch_n;
        axes    = ~it.axis_switch_n;
        if (mags[2]) rep.magnification = jpqr_pkg::MAG_HUNDRED;
        else if (mags[1]) rep.magnification = jpqr_pkg::MAG_X10;
        else if (mags[0]) rep.magnification = jpqr_pkg::MAG_X1;
        if (axes[3]) rep.axis_number = 3'd4;
        else if (axes[2]) rep.axis_number = 3'd3;
        else if (axes[1]) rep.axis_number = 3'd2;
        else if (axes[0]) rep.axis_number = 3'd1;
        if (taken != 0 && rep.magnification != jpqr_pkg::MAG_NONE &&
            rep.axis_number != 0) begin
          rep.report_kind = jpqr_pkg::KIND_STEP;
          rep.step_count  = taken;
          gave            = 1'b1;
        end else begin
          rep = '0;
        end
      end
      // Heartbeat counter: restarts on a report, READY when it meets the limit
      if (gave) silent_ticks = '0;
      silent_ticks = silent_ticks + 8'd1;
      if (silent_ticks == heartbeat_limit) begin
        silent_ticks = '0;
        if (!gave) begin
          rep.report_kind = jpqr_pkg::KIND_READY;
          gave            = 1'b1;
        end
      end
      if (gave) report_q.push_back(rep);
    endfunction

    // Compare one output transaction with the oldest prediction
    function void check_report(logic [1:0] kind, logic [23:0] data);
      jpqr_pkg::jpqr_result_t exp;
      if (report_q.size() == 0) begin
        $error("unexpected report: kind %0d data 0x%06h", kind, data);
        errors++;
        return;
      end
      exp = report_q.pop_front();
      if (kind < 3) kind_seen[kind]++;
      if (kind != exp.report_kind) begin
        $error("report_kind: expected %0d, got %0d", exp.report_kind, kind);
        errors++;
      end
      if (data[2:0] != exp.axis_number) begin
        $error("axis_number: expected %0d, got %0d", exp.axis_number, data[2:0]);
        errors++;
      end
      if (data[9:3] != exp.magnification) begin
        $error("magnification: expected %0d, got %0d", exp.magnification, data[9:3]);
        errors++;
      end
      if (data[17:10] != exp.step_count) begin
        $error("step_count: expected %0d, got %0d", exp.step_count,
               $signed(data[17:10]));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  jog_report_scoreboard sb;
  bit         gaps_on;
  int         sent_count;
  int         settings_used;
  logic [1:0] last_pair;

  jog_pendant_quadrature_reporter dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: stall at random unless gaps are switched off
  always @(posedge clk) begin
    m_tready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Monitor both channels at the clock edge
  always @(posedge clk) begin
    jpqr_pkg::jpqr_item_t seen;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.command       = s_tuser;
        seen.pin_a         = s_tdata[0];
        seen.pin_b         = s_tdata[1];
        seen.estop_level   = s_tdata[2];
        seen.mag_switch_n  = s_tdata[5:3];
        seen.axis_switch_n = s_tdata[9:6];
        sb.note_input(seen);
      end
      if (m_tvalid && m_tready) sb.check_report(m_tuser, m_tdata);
    end
  end

  function automatic jpqr_pkg::jpqr_item_t make_tick(logic estop, logic [2:0] mag_n,
                                                     logic [3:0] axis_n);
    jpqr_pkg::jpqr_item_t it;
    it.command       = jpqr_pkg::CMD_TICK;
    it.pin_a         = 1'($urandom_range(1));
    it.pin_b         = 1'($urandom_range(1));
    it.estop_level   = estop;
    it.mag_switch_n  = mag_n;
    it.axis_switch_n = axis_n;
    return it;
  endfunction

  function automatic jpqr_pkg::jpqr_item_t make_pin(logic [1:0] pair);
    jpqr_pkg::jpqr_item_t it;
    it.command       = jpqr_pkg::CMD_PIN;
    it.pin_b         = pair[1];
    it.pin_a         = pair[0];
    it.estop_level   = 1'($urandom_range(1));
    it.mag_switch_n  = 3'($urandom_range(7));
    it.axis_switch_n = 4'($urandom_range(15));
    return it;
  endfunction

  // Next {B,A} pair along the Gray sequence in the chosen direction
  function automatic logic [1:0] next_pair(logic [1:0] p, bit up);
    case (p)
      2'b00:   return up ? 2'b01 : 2'b10;
      2'b01:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b10 : 2'b01;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // Offer one transaction, idling first at random, and hold until accepted
  task automatic send_item(input jpqr_pkg::jpqr_item_t it);
    while (gaps_on && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, it.axis_switch_n, it.mag_switch_n, it.estop_level, it.pin_b, it.pin_a};
    s_tuser  <= it.command;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.command == jpqr_pkg::CMD_PIN) last_pair = {it.pin_b, it.pin_a};
    sent_count++;
  endtask

  // Drop valid and hold off until every predicted report has arrived or the limit runs out
  task automatic wait_results(input int limit);
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Change the heartbeat limit once the block has gone idle
  task automatic set_heartbeat(input logic [7:0] val);
    wait_results(100_000);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.heartbeat_limit = val;
    settings_used++;
  endtask

  task automatic detent(input bit up);
    send_item(make_pin(up ? 2'b01 : 2'b10));
    send_item(make_pin(2'b11));
    send_item(make_pin(up ? 2'b10 : 2'b01));
  endtask

  task automatic turn(input bit up, input int len);
    repeat (len) send_item(make_pin(next_pair(last_pair, up)));
  endtask

  // Mostly clean handwheel turns and ticks, with some pin noise
  task automatic random_mix(input int n);
    int target;
    int r;
    target = sent_count + n;
    while (sent_count < target) begin
      r = $urandom_range(99);
      if (r < 45) turn(1'($urandom_range(1)), $urandom_range(1, 16));
      else if (r < 55) send_item(make_pin(2'($urandom_range(3))));
      else if (r < 63) send_item(make_tick(1'b1, 3'($urandom_range(7)),
                                           4'($urandom_range(15))));
      else if (r < 88) send_item(make_tick(1'b0, 3'($urandom_range(7)),
                                           4'($urandom_range(15))));
      else if (r < 94) send_item(make_tick(1'b0, 3'b111, 4'($urandom_range(15))));
      else send_item(make_tick(1'b0, 3'($urandom_range(7)), 4'b1111));
      if ($urandom_range(99) == 0) wait_results(100_000);
    end
  endtask

  // Silent ticks with no magnification, with occasional short turns, so a long heartbeat limit is reached
  task automatic quiet_run(input int n);
    int target;
    target = sent_count + n;
    while (sent_count < target) begin
      if ($urandom_range(99) < 12) turn(1'($urandom_range(1)), $urandom_range(1, 6));
      else send_item(make_tick(1'b0, 3'b111, 4'($urandom_range(15))));
    end
  endtask

  // Spin far enough forward that the step count wraps past its top
  task automatic spin_wrap();
    send_item(make_tick(1'b0, 3'b111, 4'b1111));
    turn(1'b1, 523);
    send_item(make_tick(1'b0, 3'b011, 4'b0111));
  endtask

  initial begin
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = 1'b0;
    m_tready      = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst           = 1'b1;
    gaps_on       = 1'b1;
    sent_count    = 0;
    settings_used = 0;
    last_pair     = 2'b00;
    sb = new();
    sb.restart();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: release, each magnification and axis, silent clears, stops
    send_item(make_tick(1'b0, 3'b111, 4'b1111));
    detent(1'b1);
    send_item(make_tick(1'b0, 3'b000, 4'b0000));
    detent(1'b0);
    send_item(make_tick(1'b0, 3'b101, 4'b1110));
    detent(1'b1);
    send_item(make_tick(1'b0, 3'b110, 4'b1011));
    detent(1'b1);
    send_item(make_tick(1'b0, 3'b111, 4'b1101));
    detent(1'b0);
    send_item(make_tick(1'b0, 3'b110, 4'b1111));
    send_item(make_tick(1'b1, 3'b000, 4'b0000));
    send_item(make_tick(1'b1, 3'b111, 4'b1111));
    send_item(make_tick(1'b0, 3'b011, 4'b1101));

    // Random phases across heartbeat limits, extremes included
    set_heartbeat(8'd1);
    random_mix(170);
    set_heartbeat(8'd255);
    quiet_run(400);
    set_heartbeat(8'd3);
    gaps_on = 1'b0;
    random_mix(170);
    gaps_on = 1'b1;
    set_heartbeat(8'($urandom_range(2, 254)));
    spin_wrap();
    random_mix(170);
    set_heartbeat(8'd10);
    random_mix(80);

    // Drain and settle
    wait_results(20_000);
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d predicted reports never arrived", sb.pending());
      sb.errors++;
    end
    $display("Run: %0d transactions in, %0d heartbeat settings, step wrap and estop exercised.",
             sb.items_seen, settings_used);
    $display("Reports out: %0d STOP, %0d READY, %0d STEP.",
             sb.kind_seen[jpqr_pkg::KIND_STOP], sb.kind_seen[jpqr_pkg::KIND_READY],
             sb.kind_seen[jpqr_pkg::KIND_STEP]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
